// ===== rtl/core/b32enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b32enc_pkg: shared types, constants and functions of the blech32 encoder
// Holds the payload structs, the command and status codes, the work queue
// entry, the back-end state type, the BCH step and the charset lookup.
// ----------------------------------------------------------------------------
package b32enc_pkg;

    // Prefix buffer sizing
    localparam int PREFIX_MAX = 8;
    localparam int PCNT_W     = $clog2(PREFIX_MAX + 1);
    localparam int PIDX_W     = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;

    // Checksum length in symbols
    localparam int CHK_SYMS = 12;
    localparam int IDX_W    = (PCNT_W > $clog2(CHK_SYMS)) ? PCNT_W : $clog2(CHK_SYMS);

    // Work queue depth
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Fixed overhead of a string: separator, checksum and terminator
    localparam logic [9:0] LEN_OVERHEAD = 10'(CHK_SYMS + 2);

    // Configuration register map
    localparam logic [0:0] ADDR_LENGTH_LIMIT  = 1'b0;
    localparam logic [7:0] LENGTH_LIMIT_RESET = 8'd255;

    // Input commands
    localparam logic [1:0] CMD_PREFIX = 2'd0;
    localparam logic [1:0] CMD_SYMBOL = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_PREFIX  = 3'd1;
    localparam logic [2:0] ST_BAD_SYMBOL  = 3'd2;
    localparam logic [2:0] ST_PREFIX_LONG = 3'd3;
    localparam logic [2:0] ST_ORDER       = 3'd4;
    localparam logic [2:0] ST_OVER_LIMIT  = 3'd5;

    // Prefix character range
    localparam logic [7:0] CHAR_LOW   = 8'd33;
    localparam logic [7:0] CHAR_HIGH  = 8'd126;
    localparam logic [7:0] UPPER_LOW  = 8'd65;
    localparam logic [7:0] UPPER_HIGH = 8'd90;
    localparam logic [7:0] SYM_LIMIT  = 8'd32;

    localparam logic [6:0] SEPARATOR = 7'h31;

    // BCH generator and final constants
    localparam logic [59:0] GEN [5] = '{
        60'h07d52fba40bd886,
        60'h05e8dbf1a03950c,
        60'h01c3a3c74072a18,
        60'h0385d72fa0e5139,
        60'h07093e5a608865b
    };
    localparam logic [59:0] POLY_INIT = 60'h1;
    localparam logic [59:0] FINAL_M   = 60'h455972a3350f7a1;

    localparam logic [255:0] CHARSET_STR = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] value;
        logic       variant_m;
    } item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       char_valid;
        logic [2:0] status;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        OP_PREFIX,
        OP_SYMBOL,
        OP_FINISH
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [6:0] data;
        logic [2:0] err;
        logic       vm;
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PFX,
        S_FHI,
        S_FZERO,
        S_FLO,
        S_SEP,
        S_SYM,
        S_FSTEP,
        S_FEMIT,
        S_ERR
    } back_state_t;

    function automatic logic [59:0] bch_step(input logic [59:0] p);
        logic [59:0] r;
        r = {p[54:0], 5'b00000};
        for (int k = 0; k < 5; k++)
        begin
            if (p[55 + k])
            begin
                r = r ^ GEN[k];
            end
        end
        return r;
    endfunction

    function automatic logic [6:0] charset_char(input logic [4:0] sym);
        logic [4:0] pos;
        pos = 5'd31 - sym;
        return CHARSET_STR[{pos, 3'b000} +: 7];
    endfunction

endpackage

// ===== rtl/core/b32enc_front.sv =====
// ----------------------------------------------------------------------------
// b32enc_front: input classifier
// Validates each item against the string state, keeps the sticky error and
// the length bookkeeping, and queues work for the back end.
// ----------------------------------------------------------------------------
module b32enc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  b32enc_pkg::item_t   item,
    input  logic [7:0]          length_limit,
    input  logic                q_full,
    output logic                push,
    output b32enc_pkg::op_t     push_op
);

    logic [b32enc_pkg::PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic                          folded_reg, folded_next;
    logic [7:0]                    scnt_reg, scnt_next;
    logic [2:0]                    err_reg, err_next;

    logic       accept;
    logic       char_ok;
    logic [9:0] total_len;
    logic [2:0] fin_err;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    assign char_ok = (item.value >= b32enc_pkg::CHAR_LOW) && (item.value <= b32enc_pkg::CHAR_HIGH)
                     && !((item.value >= b32enc_pkg::UPPER_LOW)
                          && (item.value <= b32enc_pkg::UPPER_HIGH));

    assign total_len = 10'(pcnt_reg) + 10'(scnt_reg) + b32enc_pkg::LEN_OVERHEAD;

    always_comb
    begin
        if (err_reg != b32enc_pkg::ST_OK)
        begin
            fin_err = err_reg;
        end
        else if (total_len > 10'(length_limit))
        begin
            fin_err = b32enc_pkg::ST_OVER_LIMIT;
        end
        else
        begin
            fin_err = b32enc_pkg::ST_OK;
        end
    end

    always_comb
    begin
        pcnt_next   = pcnt_reg;
        folded_next = folded_reg;
        scnt_next   = scnt_reg;
        err_next    = err_reg;
        push        = 1'b0;
        push_op     = '{kind: b32enc_pkg::OP_PREFIX, data: item.value[6:0],
                        err: fin_err, vm: item.variant_m};
        if (accept)
        begin
            unique case (item.command)
                b32enc_pkg::CMD_PREFIX:
                begin
                    if (!char_ok)
                    begin
                        if (err_reg == b32enc_pkg::ST_OK) err_next = b32enc_pkg::ST_BAD_PREFIX;
                    end
                    else if (folded_reg)
                    begin
                        if (err_reg == b32enc_pkg::ST_OK) err_next = b32enc_pkg::ST_ORDER;
                    end
                    else if (pcnt_reg >= b32enc_pkg::PCNT_W'(b32enc_pkg::PREFIX_MAX))
                    begin
                        if (err_reg == b32enc_pkg::ST_OK) err_next = b32enc_pkg::ST_PREFIX_LONG;
                    end
                    else
                    begin
                        push      = 1'b1;
                        pcnt_next = pcnt_reg + 1'b1;
                    end
                end
                b32enc_pkg::CMD_SYMBOL:
                begin
                    if (item.value >= b32enc_pkg::SYM_LIMIT)
                    begin
                        if (err_reg == b32enc_pkg::ST_OK) err_next = b32enc_pkg::ST_BAD_SYMBOL;
                    end
                    else
                    begin
                        push         = 1'b1;
                        push_op.kind = b32enc_pkg::OP_SYMBOL;
                        folded_next  = 1'b1;
                        if (scnt_reg != 8'hff) scnt_next = scnt_reg + 8'd1;
                    end
                end
                b32enc_pkg::CMD_FINISH:
                begin
                    push         = 1'b1;
                    push_op.kind = b32enc_pkg::OP_FINISH;
                    pcnt_next    = '0;
                    folded_next  = 1'b0;
                    scnt_next    = '0;
                    err_next     = b32enc_pkg::ST_OK;
                end
                default:
                begin
                    // unused command: drop
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg   <= '0;
            folded_reg <= 1'b0;
            scnt_reg   <= '0;
            err_reg    <= b32enc_pkg::ST_OK;
        end
        else
        begin
            pcnt_reg   <= pcnt_next;
            folded_reg <= folded_next;
            scnt_reg   <= scnt_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ===== rtl/core/b32enc_queue.sv =====
// ----------------------------------------------------------------------------
// b32enc_queue: work queue
// Short FIFO of classified operations between the front and the back end.
// ----------------------------------------------------------------------------
module b32enc_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b32enc_pkg::op_t push_op,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output b32enc_pkg::op_t head
);

    b32enc_pkg::op_t                 mem [b32enc_pkg::Q_DEPTH];
    logic [b32enc_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [b32enc_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [b32enc_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                            do_push, do_pop;

    assign full    = (cnt_reg == b32enc_pkg::QCNT_W'(b32enc_pkg::Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // advance a pointer with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == b32enc_pkg::QPTR_W'(b32enc_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == b32enc_pkg::QPTR_W'(b32enc_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/b32enc_back.sv =====
// ----------------------------------------------------------------------------
// b32enc_back: checksum engine
// Runs one BCH step per cycle over the prefix fold, the data symbols (held by
// a result stall) and the checksum tail; drives the registered result port.
// ----------------------------------------------------------------------------
module b32enc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  b32enc_pkg::op_t     q_head,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output b32enc_pkg::result_t result
);

    b32enc_pkg::back_state_t        state_reg, state_next;
    b32enc_pkg::op_t                op_reg, op_next;
    logic [59:0]                    poly_reg, poly_next;
    logic [b32enc_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [b32enc_pkg::PCNT_W-1:0]  pcnt_reg, pcnt_next;
    logic                           folded_reg, folded_next;
    logic [6:0]                     store [b32enc_pkg::PREFIX_MAX];
    logic                           store_we;

    logic                           res_valid_reg, res_valid_next;
    b32enc_pkg::result_t            res_reg, res_next;
    logic                           emit;
    b32enc_pkg::result_t            emit_res;

    logic                           out_free;
    logic [59:0]                    step;
    logic [6:0]                     store_rd_reg;
    logic                           fold_end;
    logic                           chk_end;

    assign out_free = !res_valid_reg || !result_stall;
    assign step     = b32enc_pkg::bch_step(poly_reg);
    assign fold_end = ((idx_reg + 1'b1) == b32enc_pkg::IDX_W'(pcnt_reg));
    assign chk_end  = (idx_reg == b32enc_pkg::IDX_W'(b32enc_pkg::CHK_SYMS - 1));

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            b32enc_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.kind == b32enc_pkg::OP_PREFIX)
                    begin
                        state_next = b32enc_pkg::S_PFX;
                    end
                    else if ((q_head.kind == b32enc_pkg::OP_FINISH)
                             && (q_head.err != b32enc_pkg::ST_OK))
                    begin
                        state_next = b32enc_pkg::S_ERR;
                    end
                    else if (folded_reg)
                    begin
                        state_next = (q_head.kind == b32enc_pkg::OP_SYMBOL)
                                     ? b32enc_pkg::S_SYM : b32enc_pkg::S_FSTEP;
                    end
                    else
                    begin
                        state_next = (pcnt_reg == '0) ? b32enc_pkg::S_FZERO : b32enc_pkg::S_FHI;
                    end
                end
            end
            b32enc_pkg::S_PFX:
            begin
                if (out_free) state_next = b32enc_pkg::S_IDLE;
            end
            b32enc_pkg::S_FHI:
            begin
                if (fold_end) state_next = b32enc_pkg::S_FZERO;
            end
            b32enc_pkg::S_FZERO:
            begin
                state_next = (pcnt_reg == '0) ? b32enc_pkg::S_SEP : b32enc_pkg::S_FLO;
            end
            b32enc_pkg::S_FLO:
            begin
                if (fold_end) state_next = b32enc_pkg::S_SEP;
            end
            b32enc_pkg::S_SEP:
            begin
                if (out_free)
                begin
                    state_next = (op_reg.kind == b32enc_pkg::OP_SYMBOL)
                                 ? b32enc_pkg::S_SYM : b32enc_pkg::S_FSTEP;
                end
            end
            b32enc_pkg::S_SYM:
            begin
                if (out_free) state_next = b32enc_pkg::S_IDLE;
            end
            b32enc_pkg::S_FSTEP:
            begin
                if (chk_end) state_next = b32enc_pkg::S_FEMIT;
            end
            b32enc_pkg::S_FEMIT:
            begin
                if (out_free && chk_end) state_next = b32enc_pkg::S_IDLE;
            end
            b32enc_pkg::S_ERR:
            begin
                if (out_free) state_next = b32enc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = b32enc_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next     = op_reg;
        poly_next   = poly_reg;
        idx_next    = idx_reg;
        pcnt_next   = pcnt_reg;
        folded_next = folded_reg;
        store_we    = 1'b0;
        pop         = 1'b0;
        emit        = 1'b0;
        emit_res    = '{out_char: op_reg.data, char_valid: 1'b1,
                        status: b32enc_pkg::ST_OK, last: 1'b0};
        unique case (state_reg)
            b32enc_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    op_next  = q_head;
                    idx_next = '0;
                end
            end
            b32enc_pkg::S_PFX:
            begin
                if (out_free)
                begin
                    store_we  = 1'b1;
                    pcnt_next = pcnt_reg + 1'b1;
                    emit      = 1'b1;
                end
            end
            b32enc_pkg::S_FHI:
            begin
                poly_next = step ^ 60'(store_rd_reg[6:5]);
                idx_next  = fold_end ? '0 : idx_reg + 1'b1;
            end
            b32enc_pkg::S_FZERO:
            begin
                poly_next = step;
                idx_next  = '0;
            end
            b32enc_pkg::S_FLO:
            begin
                poly_next = step ^ 60'(store_rd_reg[4:0]);
                idx_next  = fold_end ? '0 : idx_reg + 1'b1;
            end
            b32enc_pkg::S_SEP:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    emit_res.out_char = b32enc_pkg::SEPARATOR;
                    folded_next       = 1'b1;
                    idx_next          = '0;
                end
            end
            b32enc_pkg::S_SYM:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    emit_res.out_char = b32enc_pkg::charset_char(op_reg.data[4:0]);
                    poly_next         = step ^ 60'(op_reg.data[4:0]);
                end
            end
            b32enc_pkg::S_FSTEP:
            begin
                if (chk_end)
                begin
                    poly_next = step ^ (op_reg.vm ? b32enc_pkg::FINAL_M : b32enc_pkg::POLY_INIT);
                    idx_next  = '0;
                end
                else
                begin
                    poly_next = step;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            b32enc_pkg::S_FEMIT:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    emit_res.out_char = b32enc_pkg::charset_char(poly_reg[59:55]);
                    emit_res.last     = chk_end;
                    poly_next         = {poly_reg[54:0], 5'b00000};
                    idx_next          = idx_reg + 1'b1;
                    if (chk_end)
                    begin
                        poly_next   = b32enc_pkg::POLY_INIT;
                        pcnt_next   = '0;
                        folded_next = 1'b0;
                        idx_next    = '0;
                    end
                end
            end
            b32enc_pkg::S_ERR:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_res    = '{out_char: 7'd0, char_valid: 1'b0,
                                    status: op_reg.err, last: 1'b1};
                    poly_next   = b32enc_pkg::POLY_INIT;
                    pcnt_next   = '0;
                    folded_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // hold the result while stalled, drop it once taken
    always_comb
    begin
        res_next = res_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
            res_next       = emit_res;
        end
        else
        begin
            res_valid_next = res_valid_reg && result_stall;
        end
    end

    // prefetch the prefix entry that the next fold step reads
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store[pcnt_reg[b32enc_pkg::PIDX_W-1:0]] <= op_reg.data;
        end
        store_rd_reg <= store[idx_next[b32enc_pkg::PIDX_W-1:0]];
        op_reg       <= op_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= b32enc_pkg::S_IDLE;
            poly_reg      <= b32enc_pkg::POLY_INIT;
            idx_reg       <= '0;
            pcnt_reg      <= '0;
            folded_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            poly_reg      <= poly_next;
            idx_reg       <= idx_next;
            pcnt_reg      <= pcnt_next;
            folded_reg    <= folded_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ===== rtl/core/blech32_checksum_encoder.sv =====
// ----------------------------------------------------------------------------
// blech32_checksum_encoder: streaming blech32 string encoder
// Echoes the prefix, folds it into the 60-bit BCH checksum, maps data
// symbols to charset characters and appends the twelve-character checksum.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  item      in         item_valid / item_stall  item_t   {command, value, variant_m}
//  result    out        result_valid / result_stall result_t {out_char, char_valid,
//                                                            status, last}
//  config    in         APB psel/penable/pwrite  length_limit at byte address 0
//
//  The front classifies one item per cycle into a two-entry work queue; it stalls
//  only when that queue is full.
//  The back end does one BCH step per cycle unless a result stall holds it:
//  a prefix character is dispatched and echoed, a symbol dispatched and echoed
//  with a step, after the fold on the first one; a finish runs 12 steps and
//  emits 12 characters, after the fold when no symbol came; an error finish closes.
//  A stall on the result port holds the back end at its next emit; the front keeps
//  accepting until the queue fills.
//  Reset clears the string state and sets length_limit to 255; no clearing pass.
// ----------------------------------------------------------------------------
module blech32_checksum_encoder
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  b32enc_pkg::item_t   item,
    output logic                result_valid,
    input  logic                result_stall,
    output b32enc_pkg::result_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [0:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [7:0]      length_limit_reg, length_limit_next;
    logic            cfg_write;

    logic            q_push;
    b32enc_pkg::op_t q_push_op;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    b32enc_pkg::op_t q_head;

    // Configuration: zero-wait APB, write lands on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        length_limit_next = length_limit_reg;
        if (cfg_write && (paddr == b32enc_pkg::ADDR_LENGTH_LIMIT))
        begin
            length_limit_next = pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == b32enc_pkg::ADDR_LENGTH_LIMIT)
        begin
            prdata = {24'd0, length_limit_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_limit_reg <= b32enc_pkg::LENGTH_LIMIT_RESET;
        end
        else
        begin
            length_limit_reg <= length_limit_next;
        end
    end

    // Front: validate, track sticky error and length, queue work
    b32enc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .length_limit (length_limit_reg),
        .q_full       (q_full),
        .push         (q_push),
        .push_op      (q_push_op)
    );

    // Decouple classification from the multi-cycle checksum work
    b32enc_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .pop     (q_pop),
        .full    (q_full),
        .empty   (q_empty),
        .head    (q_head)
    );

    // Back: polymod engine and result register
    b32enc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== rtl/core/b32enc_checker.sv =====
// ----------------------------------------------------------------------------
// b32enc_checker: port-level checks of the blech32 encoder
// Watches the result and configuration ports and flags illegal sequences.
// ----------------------------------------------------------------------------
module b32enc_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_stall,
    input b32enc_pkg::result_t result,
    input logic                pready
);

    // a stalled transfer holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // an error status only comes on the closing, characterless result
    a_error_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != b32enc_pkg::ST_OK)
        |-> result.last && !result.char_valid)
        else $error("error status on a non-final result");

    // a result without a character is always an error close
    a_empty_is_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.char_valid
        |-> result.last && (result.status != b32enc_pkg::ST_OK))
        else $error("empty result without error");

    // every emitted character is printable
    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.char_valid
        |-> (result.out_char >= 7'd33) && (result.out_char <= 7'd126))
        else $error("non-printable character emitted");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind blech32_checksum_encoder b32enc_checker u_b32enc_checker (.*);
